// ===== rtl/core/ddpid_pkg.sv =====
// Shared types, widths and constants of the differential drive PID controller.
`timescale 1ns / 1ps

package ddpid_pkg;

    // Field and register widths.
    localparam int FIELD_W  = 24;
    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = 4 * FIELD_W;
    localparam int M_DATA_W = ((2 * DRIVE_W + 7) / 8) * 8;

    // Internal datapath widths.
    localparam int E1_W   = FIELD_W + 1;          // target minus wheel one position
    localparam int HB_W   = FIELD_W + 2;          // heading target plus |wheel two position|
    localparam int E_W    = 32;                   // scaled errors and the integrator
    localparam int B_W    = E_W + 1;              // multiplier data operand
    localparam int PROD_W = GAIN_W + B_W;
    localparam int Q_W    = PROD_W - 8;           // product after the Q8.8 scaling
    localparam int ACC_W  = Q_W + 2;
    localparam int WCL_W  = 9;                    // wheel term after its clamp
    localparam int HCL_W  = 8;                    // heading term after its clamp

    localparam logic signed [ACC_W-1:0] WHEEL_LIMIT = ACC_W'(200);
    localparam logic signed [ACC_W-1:0] HEAD_LIMIT  = ACC_W'(100);
    localparam logic signed [GAIN_W-1:0] RATIO_RESET = GAIN_W'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RD    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO = 3'd7;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE   = 4'd0,
        MUL_RT     = 4'd1,
        MUL_RP1    = 4'd2,
        MUL_LP_E1  = 4'd3,
        MUL_LD_DE1 = 4'd4,
        MUL_RP_E2  = 4'd5,
        MUL_RD_DE2 = 4'd6,
        MUL_HP_E   = 4'd7,
        MUL_HD_DE  = 4'd8,
        MUL_HI_SUM = 4'd9
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     e2_wr;
        logic     ea_wr;
        logic     e_wr;
        logic     w1_set;
        logic     w1_add;
        logic     w2_set;
        logic     w2_add;
        logic     h_set;
        logic     h_add;
        logic     finish;
        logic     out_wr;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/core/ddpid_ctrl.sv =====
// Sequencer that steps one control tick through the shared multiplier datapath.
`timescale 1ns / 1ps

module ddpid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  ddpid_pkg::t_sts i_sts,
    output ddpid_pkg::t_cmd o_cmd
);
    import ddpid_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_S1   = 14'b00000000000010,
        ST_S2   = 14'b00000000000100,
        ST_S3   = 14'b00000000001000,
        ST_S4   = 14'b00000000010000,
        ST_S5   = 14'b00000000100000,
        ST_S6   = 14'b00000001000000,
        ST_S7   = 14'b00000010000000,
        ST_S8   = 14'b00000100000000,
        ST_S9   = 14'b00001000000000,
        ST_S10  = 14'b00010000000000,
        ST_S11  = 14'b00100000000000,
        ST_S12  = 14'b01000000000000,
        ST_S13  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    // A product issued in one state is scaled in the next and used in the one after.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_S1;
                end
            end
            ST_S1: begin
                o_cmd.mul_sel = MUL_RT;
                n_state       = ST_S2;
            end
            ST_S2: begin
                o_cmd.mul_sel = MUL_RP1;
                n_state       = ST_S3;
            end
            ST_S3: begin
                o_cmd.mul_sel = MUL_LP_E1;
                o_cmd.e2_wr   = 1'b1;
                n_state       = ST_S4;
            end
            ST_S4: begin
                o_cmd.mul_sel = MUL_LD_DE1;
                o_cmd.ea_wr   = 1'b1;
                n_state       = ST_S5;
            end
            ST_S5: begin
                o_cmd.mul_sel = MUL_RP_E2;
                o_cmd.w1_set  = 1'b1;
                o_cmd.e_wr    = 1'b1;
                n_state       = ST_S6;
            end
            ST_S6: begin
                o_cmd.mul_sel = MUL_RD_DE2;
                o_cmd.w1_add  = 1'b1;
                n_state       = ST_S7;
            end
            ST_S7: begin
                o_cmd.mul_sel = MUL_HP_E;
                o_cmd.w2_set  = 1'b1;
                n_state       = ST_S8;
            end
            ST_S8: begin
                o_cmd.mul_sel = MUL_HD_DE;
                o_cmd.w2_add  = 1'b1;
                n_state       = ST_S9;
            end
            ST_S9: begin
                o_cmd.mul_sel = MUL_HI_SUM;
                o_cmd.h_set   = 1'b1;
                n_state       = ST_S10;
            end
            ST_S10: begin
                o_cmd.h_add = 1'b1;
                n_state     = ST_S11;
            end
            ST_S11: begin
                o_cmd.h_add = 1'b1;
                n_state     = ST_S12;
            end
            ST_S12: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_S13;
            end
            ST_S13: begin
                // Wait here only while the previous result still sits unread.
                if (!i_sts.out_busy) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/ddpid_dp.sv =====
// Datapath: gain registers, shared multiplier, accumulators, clamps and result register.
`timescale 1ns / 1ps

module ddpid_dp (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [ddpid_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [ddpid_pkg::GAIN_W-1:0]               i_cfg_data,
    input  logic [ddpid_pkg::S_DATA_W-1:0]             i_s_tdata,
    input  ddpid_pkg::t_cmd                            i_cmd,
    output ddpid_pkg::t_sts                            o_sts,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    output logic [ddpid_pkg::M_DATA_W-1:0]             o_m_tdata
);
    import ddpid_pkg::*;

    function automatic logic signed [WCL_W-1:0] clamp_wheel(input logic signed [ACC_W-1:0] v);
        logic signed [WCL_W-1:0] res;
        begin
            if (v > WHEEL_LIMIT) begin
                res = WCL_W'(WHEEL_LIMIT);
            end else if (v < -WHEEL_LIMIT) begin
                res = -WCL_W'(WHEEL_LIMIT);
            end else begin
                res = WCL_W'(v);
            end
            return res;
        end
    endfunction

    function automatic logic signed [HCL_W-1:0] clamp_head(input logic signed [ACC_W-1:0] v);
        logic signed [HCL_W-1:0] res;
        begin
            if (v > HEAD_LIMIT) begin
                res = HCL_W'(HEAD_LIMIT);
            end else if (v < -HEAD_LIMIT) begin
                res = -HCL_W'(HEAD_LIMIT);
            end else begin
                res = HCL_W'(v);
            end
            return res;
        end
    endfunction

    // Configuration registers.
    logic signed [GAIN_W-1:0] r_hp, r_hi, r_hd, r_lp, r_ld, r_rp, r_rd, r_ratio;

    // Per-item working registers.
    logic signed [FIELD_W-1:0] r_tgt, r_p1, r_p2;
    logic signed [E1_W-1:0]    r_e1;
    logic signed [HB_W-1:0]    r_hb;
    logic signed [E_W-1:0]     r_e2, r_ea, r_e;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [Q_W-1:0]     r_q;
    logic signed [ACC_W-1:0]   r_acc1, r_acc2, r_acch;
    logic signed [WCL_W-1:0]   r_c1, r_c2;
    logic signed [HCL_W-1:0]   r_hc;

    // State carried from tick to tick.
    logic signed [E_W-1:0]     r_hsum, r_hl, r_w2l;
    logic signed [E1_W-1:0]    r_w1l;

    logic signed [DRIVE_W-1:0] r_d1, r_d2;
    logic                      r_valid;

    logic signed [FIELD_W-1:0] w_in_tgt, w_in_htgt, w_in_p1, w_in_p2;
    logic signed [HB_W-1:0]    w_abs_p2;
    logic signed [GAIN_W-1:0]  w_a;
    logic signed [B_W-1:0]     w_b;
    logic signed [PROD_W-1:0]  w_adj;
    logic signed [E_W-1:0]     w_q32;
    logic signed [E_W:0]       w_sum;
    logic signed [E_W-1:0]     w_sum_sat;

    assign w_in_tgt  = i_s_tdata[FIELD_W-1:0];
    assign w_in_htgt = i_s_tdata[2*FIELD_W-1:FIELD_W];
    assign w_in_p1   = i_s_tdata[3*FIELD_W-1:2*FIELD_W];
    assign w_in_p2   = i_s_tdata[4*FIELD_W-1:3*FIELD_W];
    assign w_abs_p2  = w_in_p2[FIELD_W-1] ? -HB_W'(w_in_p2) : HB_W'(w_in_p2);

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_RT: begin
                w_a = r_ratio;
                w_b = B_W'(r_tgt);
            end
            MUL_RP1: begin
                w_a = r_ratio;
                w_b = B_W'(r_p1);
            end
            MUL_LP_E1: begin
                w_a = r_lp;
                w_b = B_W'(r_e1);
            end
            MUL_LD_DE1: begin
                w_a = r_ld;
                w_b = B_W'(r_e1) - B_W'(r_w1l);
            end
            MUL_RP_E2: begin
                w_a = r_rp;
                w_b = B_W'(r_e2);
            end
            MUL_RD_DE2: begin
                w_a = r_rd;
                w_b = B_W'(r_e2) - B_W'(r_w2l);
            end
            MUL_HP_E: begin
                w_a = r_hp;
                w_b = B_W'(r_e);
            end
            MUL_HD_DE: begin
                w_a = r_hd;
                w_b = B_W'(r_e) - B_W'(r_hl);
            end
            MUL_HI_SUM: begin
                w_a = r_hi;
                w_b = B_W'(r_hsum);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Division by 256 truncating toward zero: bias negative products before the shift.
    assign w_adj = r_prod + (r_prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    assign w_q32 = E_W'(r_q);

    always_comb begin
        w_sum = (E_W+1)'(r_hsum) + (E_W+1)'(r_e);
        if (w_sum[E_W] != w_sum[E_W-1]) begin
            w_sum_sat = w_sum[E_W] ? {1'b1, {(E_W-1){1'b0}}} : {1'b0, {(E_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum[E_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp    <= '0;
            r_hi    <= '0;
            r_hd    <= '0;
            r_lp    <= '0;
            r_ld    <= '0;
            r_rp    <= '0;
            r_rd    <= '0;
            r_ratio <= RATIO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HP:    r_hp    <= i_cfg_data;
                REG_HI:    r_hi    <= i_cfg_data;
                REG_HD:    r_hd    <= i_cfg_data;
                REG_LP:    r_lp    <= i_cfg_data;
                REG_LD:    r_ld    <= i_cfg_data;
                REG_RP:    r_rp    <= i_cfg_data;
                REG_RD:    r_rd    <= i_cfg_data;
                REG_RATIO: r_ratio <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsum <= '0;
            r_hl   <= '0;
            r_w1l  <= '0;
            r_w2l  <= '0;
        end else if (i_cmd.finish) begin
            r_hsum <= w_sum_sat;
            r_hl   <= r_e;
            r_w1l  <= r_e1;
            r_w2l  <= r_e2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_wr) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_a) * PROD_W'(w_b);
        r_q    <= w_adj[PROD_W-1:8];
        if (i_cmd.load) begin
            r_tgt <= w_in_tgt;
            r_p1  <= w_in_p1;
            r_p2  <= w_in_p2;
            r_e1  <= E1_W'(w_in_tgt) - E1_W'(w_in_p1);
            r_hb  <= HB_W'(w_in_htgt) + w_abs_p2;
        end
        if (i_cmd.e2_wr) begin
            r_e2 <= w_q32 - E_W'(r_p2);
        end
        if (i_cmd.ea_wr) begin
            r_ea <= w_q32[E_W-1] ? -w_q32 : w_q32;
        end
        if (i_cmd.e_wr) begin
            r_e <= E_W'(r_hb) - r_ea;
        end
        if (i_cmd.w1_set) begin
            r_acc1 <= ACC_W'(r_q);
        end else if (i_cmd.w1_add) begin
            r_acc1 <= r_acc1 + ACC_W'(r_q);
        end
        if (i_cmd.w2_set) begin
            r_acc2 <= ACC_W'(r_q);
        end else if (i_cmd.w2_add) begin
            r_acc2 <= r_acc2 + ACC_W'(r_q);
        end
        if (i_cmd.h_set) begin
            r_acch <= ACC_W'(r_q);
        end else if (i_cmd.h_add) begin
            r_acch <= r_acch + ACC_W'(r_q);
        end
        if (i_cmd.finish) begin
            r_c1 <= clamp_wheel(r_acc1);
            r_c2 <= clamp_wheel(r_acc2);
            r_hc <= clamp_head(r_acch);
        end
        if (i_cmd.out_wr) begin
            r_d1 <= DRIVE_W'(r_c1) + DRIVE_W'(r_hc);
            r_d2 <= DRIVE_W'(r_c2) - DRIVE_W'(r_hc);
        end
    end

    assign o_sts.out_busy = r_valid && !i_m_tready;
    assign o_m_tvalid     = r_valid;
    assign o_m_tdata      = {{(M_DATA_W-2*DRIVE_W){1'b0}}, r_d2, r_d1};

endmodule

// ===== rtl/core/differential_drive_pid_controller_core.sv =====
// One input item is worked on at a time: a new item is taken only once the sequencer has
// written the previous result, after the nine products are sequenced through one
// 16 x 33 bit multiplier with a two-register scaling pipeline; a stalled output holds it.
// The next input item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) clears the sequencer, the output valid, all tick history
// and the gains; the wheel ratio resets to 1.0.
`timescale 1ns / 1ps

module differential_drive_pid_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ddpid_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ddpid_pkg::GAIN_W-1:0]          i_cfg_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // target_ticks, heading_target, wheel1_position, wheel2_position (24 bits each)
    input  logic [ddpid_pkg::S_DATA_W-1:0]        i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // drive1 [9:0], drive2 [19:10], zero fill above
    output logic [ddpid_pkg::M_DATA_W-1:0]        o_m_tdata
);
    import ddpid_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ddpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ddpid_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== rtl/core/ddpid_chk.sv =====
// Port-level checker for the differential drive PID controller, bound to the top level.
`timescale 1ns / 1ps

module ddpid_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_tvalid,
    input logic                                  o_s_tready,
    input logic                                  o_m_tvalid,
    input logic                                  i_m_tready,
    input logic [ddpid_pkg::M_DATA_W-1:0]        o_m_tdata
);
    import ddpid_pkg::*;

    logic signed [DRIVE_W-1:0] w_d1;
    logic signed [DRIVE_W-1:0] w_d2;

    assign w_d1 = o_m_tdata[DRIVE_W-1:0];
    assign w_d2 = o_m_tdata[2*DRIVE_W-1:DRIVE_W];

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // Wheel clamp plus heading clamp bound both drives.
    a_drive1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_d1 <= 10'sd300) && (w_d1 >= -10'sd300))
        else $error("drive1 out of range");

    a_drive2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_d2 <= 10'sd300) && (w_d2 >= -10'sd300))
        else $error("drive2 out of range");

    // One item is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready && !($rose(o_m_tvalid)))
        else $error("second item taken or result shown right after accept");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not clear the handshake state");

endmodule

bind differential_drive_pid_controller_core ddpid_chk u_ddpid_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
